FILE: hw/rtl/swnd_pkg.sv
// ----------------------------------------------------------------------------
// swnd_pkg: shared types and constants
// Widths, register indexes, controller states and the command/status bundles
// used between the near-duplicate detector controller and datapath.
// ----------------------------------------------------------------------------
package swnd_pkg;

   // window depth and derived widths
   localparam int WINDOW_MAX = 16;
   localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
   localparam int SAMPLE_W   = 32;
   localparam int TOL_W      = 32;
   localparam int K_W        = 5;
   localparam int CMP_W      = (CNT_W > K_W) ? CNT_W : K_W;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WINDOW_K  = 1'b0,
      REG_TOLERANCE = 1'b1
   } csr_reg_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_EVAL   = 2'd1,
      ST_FINISH = 2'd2
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture accepted item
      logic eval;    // register per-cell compare results
      logic finish;  // publish result, push sample into window
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free; // output register can take a new result this cycle
   } status_type;

endpackage

FILE: hw/rtl/swnd_ifs.sv
// ----------------------------------------------------------------------------
// swnd_ifs: item channels
// Valid/ready channels for input samples and per-sample results.
// ----------------------------------------------------------------------------
interface swnd_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [swnd_pkg::SAMPLE_W-1:0] sample_value;
   logic                             first_of_sequence;

   modport source (output valid, output sample_value, output first_of_sequence,
                   input ready);
   modport sink   (input valid, input sample_value, input first_of_sequence,
                   output ready);
endinterface

interface swnd_rsp_if;
   logic valid;
   logic ready;
   logic near_hit;
   logic any_hit;

   modport source (output valid, output near_hit, output any_hit, input ready);
   modport sink   (input valid, input near_hit, input any_hit, output ready);
endinterface

FILE: hw/rtl/sliding_window_near_duplicate.sv
// ----------------------------------------------------------------------------
// sliding_window_near_duplicate: near-duplicate detector over a sample window
// Each accepted item is captured, compared with all window taps in parallel
// in evaluate, then finished into the output register. The single-item
// sequencer takes no new item until this one is finished; finish waits while
// the output register is not drained. Synchronous active-high reset empties
// the window, clears the sticky flag and sets both registers to 0.
// ----------------------------------------------------------------------------
module sliding_window_near_duplicate (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [swnd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [swnd_pkg::CSR_DATA_W-1:0] csr_write_data,
   swnd_req_if.sink                        req,
   swnd_rsp_if.source                      rsp
);

   swnd_pkg::cmd_type    cmd;
   swnd_pkg::status_type status;
   swnd_pkg::state_type  state;
   logic                 ready;

   swnd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   assign req.ready = ready;

   swnd_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .sample_value      (req.sample_value),
      .first_of_sequence (req.first_of_sequence),
      .cmd               (cmd),
      .status            (status),
      .rsp               (rsp)
   );

   // an accepted item moves on to evaluation
   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state == swnd_pkg::ST_EVAL))
      else $error("accepted item did not enter evaluation");

   // finishing an item presents a result next cycle
   a_finish_to_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp.valid)
      else $error("finished item produced no result");

   // at most one command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.eval, cmd.finish}))
      else $error("overlapping datapath commands");

   // no new item while one is in flight
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state == swnd_pkg::ST_EVAL || state == swnd_pkg::ST_FINISH) |-> !req.ready)
      else $error("input accepted while busy");

endmodule

FILE: hw/rtl/swnd_cell.sv
// ----------------------------------------------------------------------------
// swnd_cell: one window compare cell
// Forms |window - sample| at 33 bits and checks it against the tolerance.
// ----------------------------------------------------------------------------
module swnd_cell (
   input  logic [swnd_pkg::SAMPLE_W-1:0] win_value,
   input  logic [swnd_pkg::SAMPLE_W-1:0] sample,
   input  logic [swnd_pkg::TOL_W-1:0]    tolerance,
   input  logic                          enable,
   output logic                          hit
);

   logic [swnd_pkg::SAMPLE_W:0] diff;
   logic [swnd_pkg::SAMPLE_W:0] mag;

   // sign-extended difference, then magnitude
   assign diff = {win_value[swnd_pkg::SAMPLE_W-1], win_value}
               - {sample[swnd_pkg::SAMPLE_W-1], sample};
   assign mag  = diff[swnd_pkg::SAMPLE_W] ? (~diff + 1'b1) : diff;

   assign hit  = enable && (mag <= {1'b0, tolerance});

endmodule

FILE: hw/rtl/swnd_ctrl.sv
// ----------------------------------------------------------------------------
// swnd_ctrl: item sequencer
// Steps each accepted item through evaluate and finish; holds in finish
// while the output register is still occupied.
// ----------------------------------------------------------------------------
module swnd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  swnd_pkg::status_type   status,
   output swnd_pkg::cmd_type      cmd,
   output swnd_pkg::state_type    state
);

   swnd_pkg::state_type state_ff;
   swnd_pkg::state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swnd_pkg::ST_IDLE: begin
            if (req_valid) state_in = swnd_pkg::ST_EVAL;
         end
         swnd_pkg::ST_EVAL: begin
            state_in = swnd_pkg::ST_FINISH;
         end
         swnd_pkg::ST_FINISH: begin
            if (status.out_free) state_in = swnd_pkg::ST_IDLE;
         end
         default: begin
            state_in = swnd_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         swnd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         swnd_pkg::ST_EVAL: begin
            cmd.eval  = 1'b1;
         end
         swnd_pkg::ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swnd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

FILE: hw/rtl/swnd_dpath.sv
// ----------------------------------------------------------------------------
// swnd_dpath: window datapath
// Holds the configuration, the sample window as a shift line (tap 0 is the
// newest sample), the compare cells, the sticky flag and the output register.
// ----------------------------------------------------------------------------
module swnd_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [swnd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [swnd_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic [swnd_pkg::SAMPLE_W-1:0]     sample_value,
   input  logic                              first_of_sequence,
   input  swnd_pkg::cmd_type                 cmd,
   output swnd_pkg::status_type              status,
   swnd_rsp_if.source                        rsp
);

   logic [swnd_pkg::K_W-1:0]      k_ff, k_in;
   logic [swnd_pkg::TOL_W-1:0]    tol_ff, tol_in;
   logic [swnd_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic [swnd_pkg::SAMPLE_W-1:0] window_ff [swnd_pkg::WINDOW_MAX];
   logic [swnd_pkg::SAMPLE_W-1:0] window_in [swnd_pkg::WINDOW_MAX];
   logic [swnd_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                          sticky_ff, sticky_in;
   logic [swnd_pkg::WINDOW_MAX-1:0] cell_hit;
   logic [swnd_pkg::WINDOW_MAX-1:0] hit_ff, hit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          near_ff, near_in;
   logic                          any_ff, any_in;
   logic                          near_now;

   // configuration registers
   always_comb begin
      k_in   = k_ff;
      tol_in = tol_ff;
      if (csr_write_en) begin
         case (swnd_pkg::csr_reg_type'(csr_index))
            swnd_pkg::REG_WINDOW_K:  k_in   = csr_write_data[swnd_pkg::K_W-1:0];
            swnd_pkg::REG_TOLERANCE: tol_in = csr_write_data[swnd_pkg::TOL_W-1:0];
            default:                 k_in   = k_ff;
         endcase
      end
   end

   // compare cells: tap i is in range when i < window_k and i < fill count
   for (genvar i = 0; i < swnd_pkg::WINDOW_MAX; i++) begin : g_cell
      logic cell_en;
      assign cell_en = (swnd_pkg::CMP_W'(i) < swnd_pkg::CMP_W'(k_ff))
                    && (swnd_pkg::CMP_W'(i) < swnd_pkg::CMP_W'(count_ff));
      swnd_cell u_cell (
         .win_value (window_ff[i]),
         .sample    (sample_ff),
         .tolerance (tol_ff),
         .enable    (cell_en),
         .hit       (cell_hit[i])
      );
   end

   assign near_now = |hit_ff;
   assign status.out_free = !rsp_valid_ff || rsp.ready;

   // item state: capture, evaluate, finish
   always_comb begin
      sample_in    = sample_ff;
      count_in     = count_ff;
      sticky_in    = sticky_ff;
      hit_in       = hit_ff;
      near_in      = near_ff;
      any_in       = any_ff;
      window_in    = window_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      if (cmd.load) begin
         sample_in = sample_value;
         if (first_of_sequence) begin
            count_in  = '0;
            sticky_in = 1'b0;
         end
      end

      if (cmd.eval) begin
         hit_in = cell_hit;
      end

      if (cmd.finish) begin
         near_in      = near_now;
         any_in       = sticky_ff || near_now;
         sticky_in    = sticky_ff || near_now;
         rsp_valid_in = 1'b1;
         window_in[0] = sample_ff;
         for (int i = 1; i < swnd_pkg::WINDOW_MAX; i++) begin
            window_in[i] = window_ff[i-1];
         end
         if (count_ff < swnd_pkg::CNT_W'(swnd_pkg::WINDOW_MAX)) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         tol_ff       <= '0;
         count_ff     <= '0;
         sticky_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         tol_ff       <= tol_in;
         count_ff     <= count_in;
         sticky_ff    <= sticky_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      window_ff <= window_in;
      hit_ff    <= hit_in;
      near_ff   <= near_in;
      any_ff    <= any_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.near_hit = near_ff;
   assign rsp.any_hit  = any_ff;

endmodule

FILE: test/sliding_window_near_duplicate_test.sv
// ----------------------------------------------------------------------------
// sliding_window_near_duplicate_test: self-checking bench for the detector
// A directed table covers the register extremes, an empty window, short
// history, window changes inside a sequence and the sign extremes. Random
// sequences with clustered values follow. Typed rows are checked against
// their table flags, other results against a software copy of window logic.
// Both channels idle at random; one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module sliding_window_near_duplicate_test;

   localparam int          RANDOM_BLOCKS  = 20;
   localparam int          BLOCK_ITEMS    = 100;
   localparam int          PRESSURE_BLOCK = 2;
   localparam int          LONG_HOLD      = 300;
   localparam int          MAX_IDLE       = 16;
   localparam int unsigned CYCLE_LIMIT    = 1000000;

   // expected flags of one result item
   typedef struct packed {
      logic near_hit;
      logic any_hit;
   } hit_flags_type;

   // one row of the directed table; reconfig writes both registers first
   typedef struct packed {
      logic        reconfig;
      logic [31:0] k_word;
      logic [31:0] tol_word;
      logic [31:0] value;
      logic        first;
      logic        typed;
      logic        near_hit;
      logic        any_hit;
   } directed_row_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            csr_write_en;
   logic [swnd_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [swnd_pkg::CSR_DATA_W-1:0] csr_write_data;

   swnd_req_if req_ch();
   swnd_rsp_if rsp_ch();

   sliding_window_near_duplicate uut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req            (req_ch),
      .rsp            (rsp_ch)
   );

   // software copy of the window and registers
   logic [31:0] recent_samples [swnd_pkg::WINDOW_MAX];
   int unsigned recent_count      = 0;
   int unsigned next_slot         = 0;
   bit          seen_hit          = 1'b0;
   logic [4:0]  span_setting      = '0;
   logic [31:0] tolerance_setting = '0;

   hit_flags_type expected_hits [$];
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count    = 0;
   bit            idle_on        = 1'b1;
   bit            hold_req       = 1'b0;
   bit            hold_taken     = 1'b0;

   directed_row_type directed_rows [24] = '{
      // after reset: window_k is 0, nothing compared
      '{1'b0, 32'd0, 32'd0, 32'd5,          1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'hFFFF_FFFB,  1'b0, 1'b1, 1'b0, 1'b0},
      // exact duplicate, then a miss keeps the sticky flag
      '{1'b1, 32'd1, 32'd0, 32'd100,        1'b1, 1'b1, 1'b0, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd100,        1'b0, 1'b1, 1'b1, 1'b1},
      '{1'b0, 32'd0, 32'd0, 32'd101,        1'b0, 1'b1, 1'b0, 1'b1},
      // widest span of values with the largest tolerance
      '{1'b1, 32'd16, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'h8000_0000,  1'b0, 1'b1, 1'b1, 1'b1},
      // window_k above the depth, tolerance one short of the full span
      '{1'b1, 32'd31, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'h8000_0000,  1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF,  1'b0, 1'b1, 1'b1, 1'b1},
      // short window: older samples drop out of reach
      '{1'b1, 32'd2, 32'd10, 32'd1000,      1'b1, 1'b1, 1'b0, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd2000,       1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd3000,       1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd1005,       1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd2995,       1'b0, 1'b0, 1'b0, 1'b0},
      // window grows inside the sequence; upper data bits are dropped
      '{1'b1, 32'hFFFF_FFE3, 32'd5, 32'd50, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd3002,       1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd3000,       1'b0, 1'b0, 1'b0, 1'b0},
      // neighbors at both ends of the signed range; new sequence clears sticky
      '{1'b1, 32'd1, 32'd1, 32'h8000_0000,  1'b1, 1'b1, 1'b0, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'h8000_0001,  1'b0, 1'b1, 1'b1, 1'b1},
      '{1'b0, 32'd0, 32'd0, 32'h7FFF_FFFF,  1'b1, 1'b1, 1'b0, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'h7FFF_FFFE,  1'b0, 1'b1, 1'b1, 1'b1},
      // empty window even with any tolerance
      '{1'b1, 32'd0, 32'hFFFF_FFFF, 32'd7,  1'b1, 1'b1, 1'b0, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd7,          1'b0, 1'b1, 1'b0, 1'b0}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // compare one sample against the window, then push it
   function automatic hit_flags_type predict_hits(input logic [31:0] value,
                                                  input logic first);
      int unsigned        span;
      int unsigned        slot;
      int unsigned        i;
      logic signed [32:0] distance;
      logic [32:0]        magnitude;
      hit_flags_type      flags;
      if (first) begin
         recent_count = 0;
         next_slot    = 0;
         seen_hit     = 1'b0;
      end
      span = (span_setting > swnd_pkg::WINDOW_MAX) ? swnd_pkg::WINDOW_MAX : span_setting;
      if (span > recent_count)
         span = recent_count;
      flags.near_hit = 1'b0;
      for (i = 0; i < span; i++) begin
         slot      = (next_slot + swnd_pkg::WINDOW_MAX - 1 - i) % swnd_pkg::WINDOW_MAX;
         // 33-bit signed difference cannot overflow
         distance  = $signed({recent_samples[slot][31], recent_samples[slot]})
                     - $signed({value[31], value});
         magnitude = distance[32] ? -distance : distance;
         if (magnitude <= {1'b0, tolerance_setting})
            flags.near_hit = 1'b1;
      end
      seen_hit                  = seen_hit | flags.near_hit;
      flags.any_hit             = seen_hit;
      recent_samples[next_slot] = value;
      next_slot                 = (next_slot + 1) % swnd_pkg::WINDOW_MAX;
      if (recent_count < swnd_pkg::WINDOW_MAX)
         recent_count++;
      return flags;
   endfunction

   function automatic int unsigned draw_idle();
      return idle_on ? $urandom_range(0, MAX_IDLE) : 0;
   endfunction

   // offer one item; valid stays high when the next item follows at once
   task automatic offer_sample(input logic [31:0] value, input logic first,
                               input logic typed, input hit_flags_type typed_flags);
      int unsigned   gap;
      hit_flags_type predicted;
      gap = draw_idle();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.sample_value      <= value;
      req_ch.first_of_sequence <= first;
      do @(posedge clock); while (!req_ch.ready);
      predicted = predict_hits(value, first);
      expected_hits.push_back(typed ? typed_flags : predicted);
   endtask

   // wait for the block to drain, then write both registers
   task automatic settle_and_configure(input logic [31:0] k_word, input logic [31:0] tol_word);
      req_ch.valid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= swnd_pkg::REG_WINDOW_K;
      csr_write_data <= k_word;
      @(posedge clock);
      csr_index      <= swnd_pkg::REG_TOLERANCE;
      csr_write_data <= tol_word;
      @(posedge clock);
      csr_write_en      <= 1'b0;
      span_setting      = k_word[4:0];
      tolerance_setting = tol_word;
   endtask

   task automatic report_mismatch(input string field_name, input logic want, input logic got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0b actual %0b", $time, field_name, want, got);
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_req && !hold_taken) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_taken = 1'b1;
         end
         stall = draw_idle();
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // result checker
   always @(posedge clock) begin
      hit_flags_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_hits.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none actual near %0b any %0b",
                     $time, rsp_ch.near_hit, rsp_ch.any_hit);
         end else begin
            want = expected_hits.pop_front();
            if (rsp_ch.near_hit !== want.near_hit)
               report_mismatch("near_hit", want.near_hit, rsp_ch.near_hit);
            if (rsp_ch.any_hit !== want.any_hit)
               report_mismatch("any_hit", want.any_hit, rsp_ch.any_hit);
         end
      end
   end

   // stimulus
   initial begin
      int unsigned blk;
      int unsigned count;
      int unsigned seq_len;
      int unsigned j;
      int          spread;
      logic [31:0] k_word;
      logic [31:0] tol_word;
      logic [31:0] base;
      logic [31:0] value;

      req_ch.valid             <= 1'b0;
      req_ch.sample_value      <= '0;
      req_ch.first_of_sequence <= 1'b0;
      csr_write_en             <= 1'b0;
      csr_index                <= swnd_pkg::REG_WINDOW_K;
      csr_write_data           <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[r]) begin
         if (directed_rows[r].reconfig)
            settle_and_configure(directed_rows[r].k_word, directed_rows[r].tol_word);
         offer_sample(directed_rows[r].value, directed_rows[r].first, directed_rows[r].typed,
                      {directed_rows[r].near_hit, directed_rows[r].any_hit});
      end

      // random blocks, each with its own register setting
      for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         case ($urandom_range(0, 5))
            0:       k_word = 32'd0;
            1:       k_word = 32'd1;
            2:       k_word = 32'd16;
            3:       k_word = 32'd31;
            4:       k_word = $urandom;
            default: k_word = $urandom_range(2, 16);
         endcase
         case ($urandom_range(0, 4))
            0:       tol_word = 32'd0;
            1:       tol_word = $urandom_range(0, 64);
            2:       tol_word = $urandom_range(0, 4096);
            3:       tol_word = $urandom;
            default: tol_word = 32'hFFFF_FFFF;
         endcase
         settle_and_configure(k_word, tol_word);
         idle_on = (blk % 4 != 1) && (blk != PRESSURE_BLOCK);
         if (blk == PRESSURE_BLOCK)
            hold_req = 1'b1;
         // values cluster around a base so near hits are common
         spread = (tolerance_setting <= 4096) ? int'(tolerance_setting) * 2 + 3 : 0;

         count = 0;
         while (count < BLOCK_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
               seq_len = $urandom_range(1, 40);
               base    = $urandom;
               for (j = 0; j < seq_len; j++) begin
                  if (spread != 0)
                     value = base + 32'($urandom_range(0, 2 * spread) - spread);
                  else
                     value = $urandom;
                  offer_sample(value, j == 0, 1'b0, '0);
               end
               count += seq_len;
            end else begin
               // noise: any value, any sequence flag
               offer_sample($urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
               count++;
            end
         end
      end

      // drain and finish
      req_ch.valid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
